>>> hdl/trtc_pkg.sv
// ----------------------------------------------------------------------------
// trtc_pkg
// Shared types and constants of the triggered ring trace capture block.
// ----------------------------------------------------------------------------
`default_nettype none

package trtc_pkg;

    localparam int RING_DEPTH = 1024;
    localparam int SAMPLE_W   = 64;
    localparam int SLOT_W     = $clog2(RING_DEPTH);
    localparam int POST_W     = SLOT_W + 1;
    localparam int POST_MIN   = 2;
    localparam int DECIM_W    = 16;
    localparam int PRE_W      = 16;
    localparam int APB_AW     = 2;
    localparam int APB_DW     = 32;

    localparam logic [APB_AW-1:0] REG_DECIMATION = APB_AW'(0);

    typedef enum logic [1:0] {
        ACT_PUSH    = 2'd0,
        ACT_ARM     = 2'd1,
        ACT_RELEASE = 2'd2,
        ACT_READ    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        MODE_FREE  = 2'd0,
        MODE_ARMED = 2'd1,
        MODE_DONE  = 2'd2
    } t_mode;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] sample_word;
        logic [15:0] pretrigger;
        logic [9:0]  read_slot;
    } t_in;

    typedef struct packed {
        logic [63:0] read_data;
        logic [9:0]  write_pointer;
        logic [1:0]  capture_state;
        logic [9:0]  trigger_position;
        logic        stored;
    } t_out;

endpackage

`default_nettype wire

>>> hdl/triggered_ring_trace_capture.sv
// A result is registered in stage one and then in the output register, which
// holds it while the output side stalls.
// Throughput: one item per cycle unless stalled; the single-port sample RAM is
// touched at most once per item (write on push or read); other state registered.
// Reset: synchronous, active low; clears mode, pointers, counters; decimation 1.
// No clearing pass: a fill mark makes never-written slots read as zero.
// ----------------------------------------------------------------------------
// triggered_ring_trace_capture
// Decimating pretrigger ring buffer with one-shot trigger and frozen capture.
// ----------------------------------------------------------------------------
`default_nettype none

module triggered_ring_trace_capture (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  trtc_pkg::t_in                i_in,
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output trtc_pkg::t_out               o_out,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [trtc_pkg::APB_AW-1:0]   paddr,
    input  wire [trtc_pkg::APB_DW-1:0]   pwdata,
    output logic [trtc_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import trtc_pkg::*;

    // configuration
    logic [DECIM_W-1:0] r_decimation;

    // capture state
    logic [SLOT_W-1:0]  r_write_slot, n_write_slot;
    logic               r_wrapped, n_wrapped;
    logic [DECIM_W-1:0] r_decim_cnt, n_decim_cnt;
    t_mode              r_mode, n_mode;
    logic [SLOT_W-1:0]  r_trig_slot, n_trig_slot;
    logic [POST_W-1:0]  r_post, n_post;
    logic [SLOT_W-1:0]  r_trig_index, n_trig_index;
    logic               r_release, n_release;

    // sample RAM
    logic [SAMPLE_W-1:0] r_store [RING_DEPTH];
    logic [SAMPLE_W-1:0] r_mem_q;

    // pipeline
    logic  r_s1_valid;
    t_out  r_s1;
    logic  r_s1_hit;
    logic  r_out_valid;
    t_out  r_out;

    logic  in_xfer, s1_adv;
    logic  do_store, rd_hit;
    t_action act;
    logic [DECIM_W-1:0] cnt_inc;
    logic [PRE_W-1:0]   pre_c;
    logic [POST_W-1:0]  pos_sum;
    t_mode mode_eff;
    logic [POST_W-1:0] post_eff;

    assign pready   = 1'b1;
    assign prdata   = (paddr == REG_DECIMATION) ? APB_DW'(r_decimation) : '0;

    assign s1_adv     = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign act        = t_action'(i_in.action);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decimation <= DECIM_W'(1);
        end else if (psel && penable && pwrite && pready) begin
            r_decimation <= pwdata[DECIM_W-1:0];
        end
    end

    always_comb begin
        n_write_slot = r_write_slot;
        n_wrapped    = r_wrapped;
        n_decim_cnt  = r_decim_cnt;
        n_mode       = r_mode;
        n_trig_slot  = r_trig_slot;
        n_post       = r_post;
        n_trig_index = r_trig_index;
        n_release    = r_release;
        do_store     = 1'b0;
        mode_eff     = r_mode;
        post_eff     = r_post;
        cnt_inc      = r_decim_cnt + DECIM_W'(1);
        pre_c        = (i_in.pretrigger > PRE_W'(RING_DEPTH - POST_MIN)) ?
                       PRE_W'(RING_DEPTH - POST_MIN) : i_in.pretrigger;
        pos_sum      = '0;
        rd_hit       = r_wrapped || (i_in.read_slot[SLOT_W-1:0] < r_write_slot);

        case (act)
            ACT_PUSH: begin
                // apply a deferred release first
                if (r_release) begin
                    n_release = 1'b0;
                    mode_eff  = MODE_FREE;
                    post_eff  = '0;
                end
                n_mode = mode_eff;
                n_post = post_eff;
                if (mode_eff != MODE_DONE) begin
                    if (cnt_inc < r_decimation) begin
                        n_decim_cnt = cnt_inc;
                    end else begin
                        n_decim_cnt = '0;
                        do_store    = 1'b1;
                        if (r_write_slot == SLOT_W'(RING_DEPTH - 1)) begin
                            n_write_slot = '0;
                            n_wrapped    = 1'b1;
                        end else begin
                            n_write_slot = r_write_slot + SLOT_W'(1);
                        end
                        if (mode_eff == MODE_ARMED) begin
                            n_post = post_eff - POST_W'(1);
                            if (post_eff == POST_W'(1)) begin
                                n_mode  = MODE_DONE;
                                pos_sum = {1'b0, r_trig_slot} + POST_W'(RING_DEPTH)
                                          - {1'b0, n_write_slot};
                                if (pos_sum >= POST_W'(RING_DEPTH)) begin
                                    pos_sum = pos_sum - POST_W'(RING_DEPTH);
                                end
                                n_trig_index = pos_sum[SLOT_W-1:0];
                            end
                        end
                    end
                end
            end
            ACT_ARM: begin
                n_release    = 1'b0;
                n_trig_slot  = r_write_slot;
                n_post       = POST_W'(RING_DEPTH) - POST_W'(pre_c);
                n_trig_index = pre_c[SLOT_W-1:0];
                n_mode       = MODE_ARMED;
            end
            ACT_RELEASE: begin
                n_release = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_slot <= '0;
            r_wrapped    <= 1'b0;
            r_decim_cnt  <= '0;
            r_mode       <= MODE_FREE;
            r_trig_slot  <= '0;
            r_post       <= '0;
            r_trig_index <= '0;
            r_release    <= 1'b0;
        end else if (in_xfer) begin
            r_write_slot <= n_write_slot;
            r_wrapped    <= n_wrapped;
            r_decim_cnt  <= n_decim_cnt;
            r_mode       <= n_mode;
            r_trig_slot  <= n_trig_slot;
            r_post       <= n_post;
            r_trig_index <= n_trig_index;
            r_release    <= n_release;
        end
    end

    // single-port access: write on push, read on read
    always_ff @(posedge i_clk) begin
        if (in_xfer && do_store) begin
            r_store[r_write_slot] <= i_in.sample_word[SAMPLE_W-1:0];
        end
        if (in_xfer && act == ACT_READ) begin
            r_mem_q <= r_store[i_in.read_slot[SLOT_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1.read_data        <= '0;
            r_s1.write_pointer    <= 10'(n_write_slot);
            r_s1.capture_state    <= n_mode;
            r_s1.trigger_position <= 10'(n_trig_index);
            r_s1.stored           <= do_store;
            r_s1_hit              <= (act == ACT_READ) && rd_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    // hold the result while stalled; merge RAM data as it leaves stage one
    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_out.read_data        <= r_s1_hit ? 64'(r_mem_q) : 64'd0;
            r_out.write_pointer    <= r_s1.write_pointer;
            r_out.capture_state    <= r_s1.capture_state;
            r_out.trigger_position <= r_s1.trigger_position;
            r_out.stored           <= r_s1.stored;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

>>> hdl/trtc_checker.sv
// ----------------------------------------------------------------------------
// trtc_checker
// Port-level assertions for the triggered ring trace capture block.
// ----------------------------------------------------------------------------
`default_nettype none

module trtc_checker (
    input wire            i_clk,
    input wire            i_rst_n,
    input wire            o_in_stall,
    input wire            o_out_valid,
    input wire            i_out_stall,
    input trtc_pkg::t_out o_out
);
    import trtc_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("result changed under stall");

    // with the result side empty there is room for an input
    a_no_stall_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty output");

    // armed trigger index is the clamped pretrigger, so it stays within the clamp
    a_armed_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.capture_state == MODE_ARMED |->
            o_out.trigger_position <= 10'(RING_DEPTH - POST_MIN))
        else $error("armed trigger position beyond clamp");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind triggered_ring_trace_capture trtc_checker u_trtc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

`default_nettype wire
